// File: design/fvad_pkg.sv
// Shared types and constants of the frame voice activity detector.
// Field widths, register indexes, reset values and the confidence constants.
// No dependencies.
package fvad_pkg;

  // Field widths
  localparam int SAMPLE_W    = 16;
  localparam int MAG_W       = 16;
  localparam int AVG_W       = 16;
  localparam int STREAK_W    = 8;
  localparam int COUNTER_W   = 16;
  localparam int CONF_W      = 10;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int DEF_MAX_FRAME_SAMPLES = 256;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PEAK_THR   = 2'd0,
    REG_AVG_THR    = 2'd1,
    REG_STREAK_THR = 2'd2,
    REG_PUBLISH    = 2'd3
  } reg_index_t;

  // Input operation codes
  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_SESSION = 1'b1
  } op_t;

  // Register reset values
  localparam logic [15:0] PEAK_THR_RESET   = 16'd1200;
  localparam logic [15:0] AVG_THR_RESET    = 16'd70;
  localparam logic [7:0]  STREAK_THR_RESET = 8'd3;
  localparam logic        PUBLISH_RESET    = 1'b0;

  // Saturation limits
  localparam logic [STREAK_W-1:0]  STREAK_SAT  = '1;
  localparam logic [COUNTER_W-1:0] COUNTER_SAT = '1;

  // Confidence score: peak part min(600, peak/10), average part min(400, 2*avg/5)
  localparam logic [MAG_W-1:0] CONF_PEAK_KNEE = 16'd6000;
  localparam logic [AVG_W-1:0] CONF_AVG_KNEE  = 16'd1000;
  localparam logic [9:0]       CONF_PEAK_MAX  = 10'd600;
  localparam logic [9:0]       CONF_AVG_MAX   = 10'd400;
  localparam logic [10:0]      CONF_LIMIT     = 11'd1000;
  // Reciprocals scaled by 2^16: ceil(2^16/10) and ceil(2^16/5), exact below the knees
  localparam logic [12:0]      PEAK_RECIP     = 13'd6554;
  localparam logic [13:0]      AVG_RECIP      = 14'd13108;

  // Accumulator control and status
  typedef struct packed {
    logic start;
    logic clear;
  } acc_ctrl_t;

  typedef struct packed {
    logic busy;
    logic full;
  } acc_stat_t;

endpackage

// File: design/fvad_audio_if.sv
// Audio input channel of the frame voice activity detector.
// Depends on fvad_pkg for field widths.
interface fvad_audio_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 operation;
  logic signed [fvad_pkg::SAMPLE_W-1:0] sample;
  logic                                 frame_end;

  modport source (output valid, operation, sample, frame_end, input ready);
  modport sink   (input valid, operation, sample, frame_end, output ready);
endinterface

// File: design/fvad_result_if.sv
// Per-frame result channel of the frame voice activity detector.
// Depends on fvad_pkg for field widths.
interface fvad_result_if;
  logic                             valid;
  logic                             ready;
  logic [fvad_pkg::MAG_W-1:0]       frame_peak;
  logic [fvad_pkg::AVG_W-1:0]       frame_average;
  logic                             frame_active;
  logic [fvad_pkg::STREAK_W-1:0]    streak;
  logic                             detected;
  logic [fvad_pkg::CONF_W-1:0]      confidence;
  logic [fvad_pkg::COUNTER_W-1:0]   session_frames;
  logic [fvad_pkg::COUNTER_W-1:0]   session_active_frames;
  logic [fvad_pkg::MAG_W-1:0]       session_peak_max;
  logic [fvad_pkg::AVG_W-1:0]       session_average_max;

  modport source (output valid, frame_peak, frame_average, frame_active, streak, detected,
                  confidence, session_frames, session_active_frames, session_peak_max,
                  session_average_max, input ready);
  modport sink   (input valid, frame_peak, frame_average, frame_active, streak, detected,
                  confidence, session_frames, session_active_frames, session_peak_max,
                  session_average_max, output ready);
endinterface

// File: design/fvad_cfg_if.sv
// Configuration write channel of the frame voice activity detector.
// Depends on fvad_pkg for index and data widths.
interface fvad_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [fvad_pkg::CFG_INDEX_W-1:0]  index;
  logic [fvad_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/frame_voice_activity_detector.sv
// Frame voice activity detector. Each audio beat carries one signed 16-bit sample, or a
// session start. A sample is folded into the frame sum and peak by a bit-serial adder and
// comparator, one bit per cycle over the sum width W = 16 + clog2(MAX_FRAME_SAMPLES+1)
// (25 at the default of 256), and no new beat is taken until the sample is folded in.
// The sample that ends a frame (frame_end, or the count reaching MAX_FRAME_SAMPLES)
// also runs a bit-serial divider for the average, then the scoring and emit steps;
// that beat yields one result beat. A session start yields none. The result sits in an
// output register, so a waiting result does not block the next sample until another
// frame completes. Configuration writes are taken in any cycle; write them only while
// the block is idle.
// Depends on fvad_pkg, the three channel interfaces, fvad_accum and fvad_div.
module frame_voice_activity_detector #(
  parameter int MAX_FRAME_SAMPLES = fvad_pkg::DEF_MAX_FRAME_SAMPLES
) (
  input  logic          clk,
  input  logic          rst,
  fvad_audio_if.sink    audio,
  fvad_result_if.source result,
  fvad_cfg_if.sink      cfg
);

  localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int SUM_W = fvad_pkg::MAG_W + CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_DIV,
    S_UPD,
    S_EMIT
  } state_t;

  state_t state;

  // Configuration registers
  logic [15:0] peak_thr;
  logic [15:0] avg_thr;
  logic [7:0]  streak_thr;
  logic        publish;

  // Session state
  logic [fvad_pkg::STREAK_W-1:0]  streak;
  logic                           published;
  logic [fvad_pkg::COUNTER_W-1:0] frame_counter;
  logic [fvad_pkg::COUNTER_W-1:0] active_counter;
  logic [fvad_pkg::MAG_W-1:0]     peak_max;
  logic [fvad_pkg::AVG_W-1:0]     avg_max;

  // Frame working registers
  logic                           fe_hold;
  logic [fvad_pkg::MAG_W-1:0]     frame_peak;
  logic [fvad_pkg::AVG_W-1:0]     frame_avg;
  logic                           frame_act;
  logic                           det;
  logic [25:0]                    peak_prod;
  logic [24:0]                    avg_prod;
  logic                           peak_big;
  logic                           avg_big;

  fvad_pkg::acc_ctrl_t            acc_ctrl;
  fvad_pkg::acc_stat_t            acc_stat;
  logic [SUM_W-1:0]               acc_sum;
  logic [fvad_pkg::MAG_W-1:0]     acc_peak;
  logic [CNT_W-1:0]               acc_count;
  logic                           div_start;
  logic                           div_busy;
  logic [fvad_pkg::AVG_W-1:0]     div_quo;

  logic                           in_beat;
  logic                           frame_done;
  logic                           act_c;
  logic [fvad_pkg::STREAK_W-1:0]  streak_next;
  logic                           det_c;
  logic [9:0]                     peak_term;
  logic [9:0]                     avg_term;
  logic [10:0]                    conf_sum;
  logic [fvad_pkg::CONF_W-1:0]    conf_c;
  logic                           out_free;

  fvad_accum #(
    .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES),
    .CNT_W             (CNT_W),
    .SUM_W             (SUM_W)
  ) u_accum (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (acc_ctrl),
    .sample (audio.sample),
    .stat   (acc_stat),
    .sum    (acc_sum),
    .peak   (acc_peak),
    .count  (acc_count)
  );

  fvad_div #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_sum),
    .divisor  (acc_count),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign audio.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;
  assign in_beat     = audio.valid && audio.ready;
  assign frame_done  = fe_hold || acc_stat.full;
  assign out_free    = !result.valid || result.ready;

  // Steer the accumulator and divider
  always_comb begin
    acc_ctrl.start = in_beat && (audio.operation == fvad_pkg::OP_SAMPLE);
    acc_ctrl.clear = (in_beat && (audio.operation == fvad_pkg::OP_SESSION)) ||
                     (state == S_ACC && !acc_stat.busy && frame_done);
    div_start      = (state == S_ACC) && !acc_stat.busy && frame_done;
  end

  // Frame decision and streak
  always_comb begin
    act_c = (frame_peak >= peak_thr) && (div_quo >= avg_thr);
    if (!act_c) begin
      streak_next = '0;
    end else if (streak == fvad_pkg::STREAK_SAT) begin
      streak_next = streak;
    end else begin
      streak_next = streak + fvad_pkg::STREAK_W'(1);
    end
    det_c = publish && !published && (streak_next >= streak_thr);
  end

  // Confidence from the registered reciprocal products
  always_comb begin
    peak_term = peak_big ? fvad_pkg::CONF_PEAK_MAX : peak_prod[25:16];
    avg_term  = avg_big ? fvad_pkg::CONF_AVG_MAX : {1'b0, avg_prod[24:16]};
    conf_sum  = {1'b0, peak_term} + {1'b0, avg_term};
    if (!det) begin
      conf_c = '0;
    end else if (conf_sum > fvad_pkg::CONF_LIMIT) begin
      conf_c = fvad_pkg::CONF_LIMIT[fvad_pkg::CONF_W-1:0];
    end else begin
      conf_c = conf_sum[fvad_pkg::CONF_W-1:0];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      peak_thr   <= fvad_pkg::PEAK_THR_RESET;
      avg_thr    <= fvad_pkg::AVG_THR_RESET;
      streak_thr <= fvad_pkg::STREAK_THR_RESET;
      publish    <= fvad_pkg::PUBLISH_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (fvad_pkg::reg_index_t'(cfg.index))
        fvad_pkg::REG_PEAK_THR:   peak_thr   <= cfg.data;
        fvad_pkg::REG_AVG_THR:    avg_thr    <= cfg.data;
        fvad_pkg::REG_STREAK_THR: streak_thr <= cfg.data[7:0];
        fvad_pkg::REG_PUBLISH:    publish    <= cfg.data[0];
      endcase
    end
  end

  // Sequencer, session state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      result.valid   <= 1'b0;
      streak         <= '0;
      published      <= 1'b0;
      frame_counter  <= '0;
      active_counter <= '0;
      peak_max       <= '0;
      avg_max        <= '0;
    end else begin
      // Drop the result beat once taken, unless the emit step reloads it
      if (result.valid && result.ready && state != S_EMIT) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            if (audio.operation == fvad_pkg::OP_SESSION) begin
              streak         <= '0;
              published      <= 1'b0;
              frame_counter  <= '0;
              active_counter <= '0;
              peak_max       <= '0;
              avg_max        <= '0;
            end else begin
              fe_hold <= audio.frame_end;
              state   <= S_ACC;
            end
          end
        end
        S_ACC: begin
          if (!acc_stat.busy) begin
            if (frame_done) begin
              frame_peak <= acc_peak;
              state      <= S_DIV;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_DIV: begin
          if (!div_busy) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          // Fold the frame into the session
          if (frame_counter != fvad_pkg::COUNTER_SAT) begin
            frame_counter <= frame_counter + fvad_pkg::COUNTER_W'(1);
          end
          if (act_c && active_counter != fvad_pkg::COUNTER_SAT) begin
            active_counter <= active_counter + fvad_pkg::COUNTER_W'(1);
          end
          if (frame_peak > peak_max) begin
            peak_max <= frame_peak;
          end
          if (div_quo > avg_max) begin
            avg_max <= div_quo;
          end
          streak    <= streak_next;
          published <= published | det_c;
          det       <= det_c;
          frame_act <= act_c;
          frame_avg <= div_quo;
          peak_prod <= frame_peak[12:0] * fvad_pkg::PEAK_RECIP;
          avg_prod  <= {div_quo[9:0], 1'b0} * fvad_pkg::AVG_RECIP;
          peak_big  <= (frame_peak >= fvad_pkg::CONF_PEAK_KNEE);
          avg_big   <= (div_quo >= fvad_pkg::CONF_AVG_KNEE);
          state     <= S_EMIT;
        end
        S_EMIT: begin
          // Hold until the output register is free
          if (out_free) begin
            result.valid                 <= 1'b1;
            result.frame_peak            <= frame_peak;
            result.frame_average         <= frame_avg;
            result.frame_active          <= frame_act;
            result.streak                <= streak;
            result.detected              <= det;
            result.confidence            <= conf_c;
            result.session_frames        <= frame_counter;
            result.session_active_frames <= active_counter;
            result.session_peak_max      <= peak_max;
            result.session_average_max   <= avg_max;
            state                        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A new result beat is only loaded from the emit step
  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == S_EMIT))
    else $error("result beat raised outside the emit step");

  // Accumulator and divider never run at once
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(acc_stat.busy && div_busy))
    else $error("accumulator and divider busy together");

  // No second detection within a session
  a_one_shot: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD && published) |=> !det)
    else $error("detection raised twice in one session");

  // The average of magnitudes cannot exceed their peak
  a_avg_le_peak: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.frame_average <= result.frame_peak))
    else $error("frame average above frame peak");

  // Confidence only travels with a detection
  a_conf_with_detect: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.detected) |-> (result.confidence == '0))
    else $error("confidence set without detection");

endmodule

// File: design/fvad_accum.sv
// Bit-serial frame accumulator: magnitude, running sum, running peak, sample count.
// One bit of the sum per cycle, LSB first. Depends on fvad_pkg.
module fvad_accum #(
  parameter int MAX_FRAME_SAMPLES = fvad_pkg::DEF_MAX_FRAME_SAMPLES,
  parameter int CNT_W             = $clog2(MAX_FRAME_SAMPLES + 1),
  parameter int SUM_W             = fvad_pkg::MAG_W + CNT_W
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fvad_pkg::acc_ctrl_t                  ctrl,
  input  logic signed [fvad_pkg::SAMPLE_W-1:0] sample,
  output fvad_pkg::acc_stat_t                  stat,
  output logic [SUM_W-1:0]                     sum,
  output logic [fvad_pkg::MAG_W-1:0]           peak,
  output logic [CNT_W-1:0]                     count
);

  localparam int STEP_W = $clog2(SUM_W);

  logic                          busy;
  logic [STEP_W-1:0]             step;
  logic [fvad_pkg::SAMPLE_W-1:0] sample_sr;
  logic [fvad_pkg::MAG_W-1:0]    mag_sr;
  logic                          neg;
  logic                          seen_one;
  logic                          carry;
  logic                          greater;

  logic                          mag_bit;
  logic                          mag_phase;
  logic [1:0]                    bit_sum;
  logic                          greater_next;
  logic [fvad_pkg::MAG_W-1:0]    mag_next;

  // Serial two's complement negate: copy up to the first one, then invert
  always_comb begin
    mag_phase    = (step < STEP_W'(fvad_pkg::MAG_W));
    mag_bit      = mag_phase & (sample_sr[0] ^ (neg & seen_one));
    bit_sum      = {1'b0, sum[0]} + {1'b0, mag_bit} + {1'b0, carry};
    // LSB-first compare: the highest differing bit decides
    greater_next = (mag_bit != peak[0]) ? mag_bit : greater;
    mag_next     = {mag_bit, mag_sr[fvad_pkg::MAG_W-1:1]};
  end

  assign stat.busy = busy;
  assign stat.full = (count == CNT_W'(MAX_FRAME_SAMPLES));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      step  <= '0;
      sum   <= '0;
      peak  <= '0;
      count <= '0;
    end else if (busy) begin
      // Advance one bit
      sample_sr <= {1'b0, sample_sr[fvad_pkg::SAMPLE_W-1:1]};
      seen_one  <= seen_one | sample_sr[0];
      carry     <= bit_sum[1];
      sum       <= {bit_sum[0], sum[SUM_W-1:1]};
      if (mag_phase) begin
        mag_sr  <= mag_next;
        greater <= greater_next;
        if (step == STEP_W'(fvad_pkg::MAG_W - 1) && greater_next) begin
          peak <= mag_next;
        end else begin
          peak <= {peak[0], peak[fvad_pkg::MAG_W-1:1]};
        end
      end
      if (step == STEP_W'(SUM_W - 1)) begin
        busy <= 1'b0;
        step <= '0;
      end else begin
        step <= step + STEP_W'(1);
      end
    end else if (ctrl.clear) begin
      // Drop the frame totals
      sum   <= '0;
      peak  <= '0;
      count <= '0;
    end else if (ctrl.start) begin
      // Load a new sample
      busy      <= 1'b1;
      step      <= '0;
      sample_sr <= sample;
      neg       <= sample[fvad_pkg::SAMPLE_W-1];
      seen_one  <= 1'b0;
      carry     <= 1'b0;
      greater   <= 1'b0;
      count     <= count + CNT_W'(1);
    end
  end

endmodule

// File: design/fvad_div.sv
// Bit-serial restoring divider: frame sum over sample count, one quotient bit a cycle.
// Depends on fvad_pkg.
module fvad_div #(
  parameter int CNT_W = 9,
  parameter int SUM_W = fvad_pkg::MAG_W + CNT_W
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [SUM_W-1:0]           dividend,
  input  logic [CNT_W-1:0]           divisor,
  output logic                       busy,
  output logic [fvad_pkg::AVG_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W);

  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  quo_sr;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  div_r;

  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              fits;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem, quo_sr[SUM_W-1]};
    diff  = trial - {1'b0, div_r};
    fits  = (trial >= {1'b0, div_r});
  end

  // The quotient never exceeds the largest magnitude, so its low bits suffice
  assign quotient = quo_sr[fvad_pkg::AVG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (busy) begin
      quo_sr <= {quo_sr[SUM_W-2:0], fits};
      rem    <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      if (step == STEP_W'(SUM_W - 1)) begin
        busy <= 1'b0;
        step <= '0;
      end else begin
        step <= step + STEP_W'(1);
      end
    end else if (start) begin
      busy   <= 1'b1;
      step   <= '0;
      quo_sr <= dividend;
      rem    <= '0;
      div_r  <= divisor;
    end
  end

endmodule

// File: tb/fvad_frame_checker.sv
`timescale 1ns / 1ps
// Frame checker for the voice activity detector testbench: watches the audio, result and
// configuration channels, predicts every frame result and compares it field by field.
// Depends on fvad_pkg and the three channel interfaces.
module fvad_frame_checker (
  input  logic   clk,
  input  logic   rst,
  fvad_audio_if  audio,
  fvad_result_if result,
  fvad_cfg_if    cfg,
  output int     fail_count,
  output int     frames_pending
);
  import fvad_pkg::*;

  typedef struct {
    logic [MAG_W-1:0]     peak;
    logic [AVG_W-1:0]     average;
    logic                 active;
    logic [STREAK_W-1:0]  streak;
    logic                 detected;
    logic [CONF_W-1:0]    confidence;
    logic [COUNTER_W-1:0] frames;
    logic [COUNTER_W-1:0] active_total;
    logic [MAG_W-1:0]     peak_max;
    logic [AVG_W-1:0]     average_max;
  } frame_result_t;

  // Frame results still owed by the block, oldest first
  frame_result_t frames_due[$];

  // Register copies
  logic [15:0] thr_peak;
  logic [15:0] thr_avg;
  logic [7:0]  thr_streak;
  logic        publish_on;

  // Frame and session state
  logic [8:0]           n_samples;
  logic [23:0]          mag_sum;
  logic [MAG_W-1:0]     peak_run;
  logic [STREAK_W-1:0]  streak_run;
  logic                 published;
  logic [COUNTER_W-1:0] frame_cnt;
  logic [COUNTER_W-1:0] active_cnt;
  logic [MAG_W-1:0]     peak_hi;
  logic [AVG_W-1:0]     avg_hi;

  task automatic start_session();
    n_samples  = '0;
    mag_sum    = '0;
    peak_run   = '0;
    streak_run = '0;
    published  = 1'b0;
    frame_cnt  = '0;
    active_cnt = '0;
    peak_hi    = '0;
    avg_hi     = '0;
  endtask

  // Peak part saturates at 600 from 6000 up, average part at 400 from 1000 up
  function automatic logic [CONF_W-1:0] confidence_of(logic [15:0] peak, logic [15:0] avg);
    int unsigned peak_part;
    int unsigned avg_part;
    peak_part = (peak >= 16'd6000) ? 600 : int'(peak) * 600 / 6000;
    avg_part  = (avg >= 16'd1000) ? 400 : int'(avg) * 400 / 1000;
    return CONF_W'((peak_part + avg_part > 1000) ? 1000 : peak_part + avg_part);
  endfunction

  // Fold one audio beat into the frame; queue a result when the frame closes
  task automatic fold_sample(logic op, logic [15:0] smp, logic fe);
    logic [15:0]   mag;
    logic [15:0]   peak;
    logic [15:0]   avg;
    frame_result_t r;
    if (op == OP_SESSION) begin
      start_session();
      return;
    end
    // -32768 folds to 16'h8000, still representable unsigned
    mag = smp[15] ? -smp : smp;
    mag_sum = mag_sum + mag;
    if (mag > peak_run) peak_run = mag;
    n_samples = n_samples + 1'b1;
    if (!fe && n_samples < DEF_MAX_FRAME_SAMPLES) return;

    peak = peak_run;
    avg = 16'(mag_sum / n_samples);
    n_samples = '0;
    mag_sum = '0;
    peak_run = '0;

    if (frame_cnt != COUNTER_SAT) frame_cnt = frame_cnt + 1'b1;
    if (peak > peak_hi) peak_hi = peak;
    if (avg > avg_hi) avg_hi = avg;

    r.active = (peak >= thr_peak) && (avg >= thr_avg);
    if (r.active) begin
      if (streak_run != STREAK_SAT) streak_run = streak_run + 1'b1;
      if (active_cnt != COUNTER_SAT) active_cnt = active_cnt + 1'b1;
    end else begin
      streak_run = '0;
    end

    // One detection per session, on the first frame that meets the streak
    r.detected = publish_on && !published && (streak_run >= thr_streak);
    r.confidence = r.detected ? confidence_of(peak, avg) : '0;
    if (r.detected) published = 1'b1;

    r.peak         = peak;
    r.average      = avg;
    r.streak       = streak_run;
    r.frames       = frame_cnt;
    r.active_total = active_cnt;
    r.peak_max     = peak_hi;
    r.average_max  = avg_hi;
    frames_due.push_back(r);
  endtask

  task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      thr_peak   = PEAK_THR_RESET;
      thr_avg    = AVG_THR_RESET;
      thr_streak = STREAK_THR_RESET;
      publish_on = PUBLISH_RESET;
      start_session();
      frames_due.delete();
      fail_count = 0;
    end else begin
      // Compare a result beat against the oldest prediction
      if (result.valid && result.ready) begin
        if (frames_due.size() == 0) begin
          $error("result beat with no frame pending");
          fail_count++;
        end else begin
          want = frames_due.pop_front();
          check_field("frame_peak", want.peak, result.frame_peak);
          check_field("frame_average", want.average, result.frame_average);
          check_field("frame_active", want.active, result.frame_active);
          check_field("streak", want.streak, result.streak);
          check_field("detected", want.detected, result.detected);
          check_field("confidence", want.confidence, result.confidence);
          check_field("session_frames", want.frames, result.session_frames);
          check_field("session_active_frames", want.active_total,
                      result.session_active_frames);
          check_field("session_peak_max", want.peak_max, result.session_peak_max);
          check_field("session_average_max", want.average_max, result.session_average_max);
        end
      end

      // Track register writes
      if (cfg.valid && cfg.ready) begin
        case (reg_index_t'(cfg.index))
          REG_PEAK_THR:   thr_peak = cfg.data;
          REG_AVG_THR:    thr_avg = cfg.data;
          REG_STREAK_THR: thr_streak = cfg.data[7:0];
          REG_PUBLISH:    publish_on = cfg.data[0];
          default: ;
        endcase
      end

      if (audio.valid && audio.ready)
        fold_sample(audio.operation, audio.sample, audio.frame_end);
    end
    frames_pending <= frames_due.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Top of the voice activity detector testbench: clock, reset, stimulus, watchdog, verdict.
// Depends on fvad_pkg, the channel interfaces, the block and fvad_frame_checker.
module tb;
  import fvad_pkg::*;

  localparam int QUIET_LIMIT     = 20000;
  localparam int SETTLE_CYCLES   = 120;
  localparam int HOLD_OFF_CYCLES = 1500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   frames_pending;
  int   send_gap_pct = 6;
  int   recv_gap_pct = 55;
  bit   hold_off_req = 1'b0;
  int   quiet_cycles = 0;

  fvad_audio_if  audio();
  fvad_result_if result();
  fvad_cfg_if    cfg();

  frame_voice_activity_detector DUT (
    .clk    (clk),
    .rst    (rst),
    .audio  (audio),
    .result (result),
    .cfg    (cfg)
  );

  fvad_frame_checker checker_inst (
    .clk            (clk),
    .rst            (rst),
    .audio          (audio),
    .result         (result),
    .cfg            (cfg),
    .fail_count     (fail_count),
    .frames_pending (frames_pending)
  );

  always #10 clk = ~clk;

  // Result side: random back-pressure, or a long hold-off on request
  initial begin
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        result.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        result.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  // Watchdog: end the run after too long with no beat on any channel
  always @(posedge clk) begin
    if ((audio.valid && audio.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Offer one audio beat, with an occasional idle gap first, and hold until taken
  task automatic put_beat(op_t op, logic [15:0] smp, logic fe);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_gap_pct) gap = $urandom_range(1, 60);
    if (gap > 0) begin
      audio.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    audio.valid     <= 1'b1;
    audio.operation <= op;
    audio.sample    <= smp;
    audio.frame_end <= fe;
    do @(posedge clk); while (!audio.ready);
  endtask

  // Drop audio valid and wait for every owed frame result
  task automatic wait_drained();
    audio.valid <= 1'b0;
    do @(posedge clk); while (frames_pending != 0);
  endtask

  task automatic write_reg(reg_index_t idx, logic [15:0] value);
    wait_drained();
    // a non-final sample may still be in the bit-serial datapath
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  // Unused upper data bits carry random values
  task automatic apply_setting(logic [15:0] peak_thr, logic [15:0] avg_thr,
                               logic [7:0] streak_thr, logic pub);
    write_reg(REG_PEAK_THR, peak_thr);
    write_reg(REG_AVG_THR, avg_thr);
    write_reg(REG_STREAK_THR, {8'($urandom), streak_thr});
    write_reg(REG_PUBLISH, {15'($urandom), pub});
  endtask

  function automatic logic [15:0] pick_sample(int amp);
    int v;
    v = int'($urandom_range(2 * amp)) - amp;
    if (v > 32767) v = 32767;
    return 16'(v);
  endfunction

  // Mostly well-formed frames of random loudness; some session starts and aborted frames
  task automatic random_traffic(int n_items);
    int sent;
    int kind;
    int len;
    int amp;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      len = $urandom_range(1, 8);
      case ($urandom_range(3))
        0: amp = 120;
        1: amp = 2500;
        2: amp = 12000;
        default: amp = 32768;
      endcase
      if (kind < 5) begin
        put_beat(OP_SESSION, 16'($urandom), 1'($urandom));
        sent++;
      end else if (kind < 10) begin
        // abort a frame part way with a session start
        for (int k = 0; k < len - 1; k++) put_beat(OP_SAMPLE, pick_sample(amp), 1'b0);
        put_beat(OP_SESSION, 16'($urandom), 1'($urandom));
        sent += len;
      end else begin
        for (int k = 0; k < len; k++) put_beat(OP_SAMPLE, pick_sample(amp), k == len - 1);
        sent += len;
      end
    end
  endtask

  initial begin
    audio.valid     <= 1'b0;
    audio.operation <= OP_SAMPLE;
    audio.sample    <= '0;
    audio.frame_end <= 1'b0;
    cfg.valid       <= 1'b0;
    cfg.index       <= REG_PEAK_THR;
    cfg.data        <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, extreme samples, threshold edge, session starts
    put_beat(OP_SAMPLE, 16'h8000, 1'b1);
    put_beat(OP_SAMPLE, 16'h7FFF, 1'b1);
    put_beat(OP_SAMPLE, 16'd1199, 1'b1);
    put_beat(OP_SAMPLE, -16'sd1200, 1'b0);
    put_beat(OP_SAMPLE, 16'd0, 1'b0);
    put_beat(OP_SAMPLE, -16'sd2, 1'b1);
    put_beat(OP_SESSION, 16'hFFFF, 1'b1);
    put_beat(OP_SAMPLE, 16'd5000, 1'b0);
    put_beat(OP_SESSION, 16'h0000, 1'b0);
    put_beat(OP_SAMPLE, 16'd100, 1'b1);
    put_beat(OP_SAMPLE, 16'd0, 1'b1);

    // Zero streak threshold: the first frame of a session detects, even a silent one
    apply_setting(16'd32768, 16'd0, 8'd0, 1'b1);
    put_beat(OP_SAMPLE, 16'h8000, 1'b1);
    put_beat(OP_SAMPLE, 16'h7FFF, 1'b1);
    put_beat(OP_SESSION, 16'h1234, 1'b0);
    put_beat(OP_SAMPLE, 16'd0, 1'b1);

    // Peak threshold above full scale: never active
    apply_setting(16'hFFFF, 16'hFFFF, 8'd1, 1'b1);
    put_beat(OP_SAMPLE, 16'h8000, 1'b1);
    put_beat(OP_SESSION, 16'h0000, 1'b1);
    put_beat(OP_SAMPLE, 16'h8000, 1'b1);

    // Slow receiver: a full frame closed by count, then a long hold-off
    send_gap_pct = 6;
    recv_gap_pct = 55;
    apply_setting(PEAK_THR_RESET, AVG_THR_RESET, STREAK_THR_RESET, 1'b1);
    for (int k = 0; k < DEF_MAX_FRAME_SAMPLES; k++)
      put_beat(OP_SAMPLE, pick_sample(32768), 1'b0);
    random_traffic(50);
    hold_off_req = 1'b1;
    repeat (30) put_beat(OP_SAMPLE, pick_sample(32768), 1'($urandom));
    apply_setting(16'($urandom_range(9000)), 16'($urandom_range(3000)),
                  8'($urandom_range(1, 5)), 1'b1);
    random_traffic(50);

    // Slow sender, with a pause until the block is drained
    send_gap_pct = 55;
    recv_gap_pct = 6;
    apply_setting(16'($urandom_range(9000)), 16'($urandom_range(3000)),
                  8'($urandom_range(1, 5)), 1'($urandom_range(3) != 0));
    random_traffic(80);
    wait_drained();
    random_traffic(80);
    apply_setting(16'd0, 16'd0, 8'd1, 1'b1);
    random_traffic(80);

    // Full rate: streak runs into saturation with the largest threshold
    send_gap_pct = 0;
    recv_gap_pct = 0;
    apply_setting(16'd0, 16'd0, 8'd255, 1'b1);
    put_beat(OP_SESSION, 16'($urandom), 1'($urandom));
    repeat (270) put_beat(OP_SAMPLE, pick_sample(32768), 1'b1);
    apply_setting(16'($urandom_range(9000)), 16'($urandom_range(3000)),
                  8'($urandom_range(1, 5)), 1'b1);
    random_traffic(60);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && frames_pending == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

// File: frame_voice_activity_detector.f
design/fvad_pkg.sv
design/fvad_audio_if.sv
design/fvad_result_if.sv
design/fvad_cfg_if.sv
design/fvad_accum.sv
design/fvad_div.sv
design/frame_voice_activity_detector.sv
tb/fvad_frame_checker.sv
tb/tb.sv
